// ===== hw/rtl/bqsm_pkg.sv =====
// Shared constants and types for the buffer queue state manager.
`timescale 1ns / 1ps

package bqsm_pkg;

  localparam int unsigned NumBuffers = 16;
  localparam int unsigned KeyW       = 4;
  localparam int unsigned LenW       = 5;
  localparam int unsigned StW        = 2;

  localparam logic [LenW-1:0] ResetCount = LenW'(2);
  localparam logic [LenW-1:0] MaxCount   = LenW'(NumBuffers);

  // Buffer state codes
  localparam logic [StW-1:0] StFree     = 2'd0;
  localparam logic [StW-1:0] StDequeued = 2'd1;
  localparam logic [StW-1:0] StQueued   = 2'd2;
  localparam logic [StW-1:0] StAcquired = 2'd3;

  // Request kinds
  localparam logic [1:0] KindRequest = 2'd0;
  localparam logic [1:0] KindSync    = 2'd1;
  localparam logic [1:0] KindReinit  = 2'd2;

  typedef struct packed {
    logic push;
    logic remove;
  } list_op_t;

  typedef struct packed {
    logic has;
    logic full;
  } list_stat_t;

  typedef struct packed {
    logic     ok;
    list_op_t free_op;
    list_op_t data_op;
  } move_t;

endpackage

// ===== hw/rtl/bqsm_list.sv =====
// Ordered key list with membership search, tail push and compacting removal.
`timescale 1ns / 1ps

module bqsm_list import bqsm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            reinit_i,
  input  logic [LenW-1:0] reinit_len_i,
  input  list_op_t        op_i,
  input  logic [KeyW-1:0] key_i,
  output list_stat_t      stat_o,
  output logic            head_valid_o,
  output logic [KeyW-1:0] head_key_o,
  output logic [LenW-1:0] len_o
);

  logic [KeyW-1:0]       order_q [NumBuffers];
  logic [KeyW-1:0]       order_d [NumBuffers];
  logic [LenW-1:0]       len_q, len_d;
  logic [NumBuffers-1:0] hit;
  logic [NumBuffers-1:0] past_hit;

  always_comb begin
    for (int i = 0; i < NumBuffers; i++) begin
      hit[i] = (LenW'(i) < len_q) && (order_q[i] == key_i);
    end
    past_hit[0] = hit[0];
    for (int i = 1; i < NumBuffers; i++) begin
      past_hit[i] = past_hit[i-1] | hit[i];
    end
  end

  assign stat_o.has  = |hit;
  assign stat_o.full = (len_q == MaxCount);

  always_comb begin
    for (int i = 0; i < NumBuffers; i++) begin
      order_d[i] = order_q[i];
    end
    len_d = len_q;
    if (reinit_i) begin
      for (int i = 0; i < NumBuffers; i++) begin
        order_d[i] = KeyW'(i);
      end
      len_d = reinit_len_i;
    end else if (op_i.remove) begin
      // close the gap: everything from the match onward moves down one slot
      for (int i = 0; i < NumBuffers - 1; i++) begin
        if (past_hit[i]) begin
          order_d[i] = order_q[i+1];
        end
      end
      len_d = len_q - LenW'(1);
    end else if (op_i.push) begin
      order_d[len_q[KeyW-1:0]] = key_i;
      len_d = len_q + LenW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumBuffers; i++) begin
      order_q[i] <= order_d[i];
    end
  end

  assign head_valid_o = (len_q != '0);
  assign head_key_o   = head_valid_o ? order_q[0] : '0;
  assign len_o        = len_q;

endmodule

// ===== hw/rtl/bqsm_rules.sv =====
// Producer/consumer transition rules: decides a move and the list updates it needs.
`timescale 1ns / 1ps

module bqsm_rules import bqsm_pkg::*; (
  input  logic [1:0]     kind_i,
  input  logic           in_range_i,
  input  logic [StW-1:0] cur_i,
  input  logic [StW-1:0] tgt_i,
  input  list_stat_t     free_i,
  input  list_stat_t     data_i,
  output move_t          move_o
);

  logic go;

  always_comb begin
    case (kind_i)
      KindRequest: go = in_range_i;
      KindSync:    go = in_range_i &&
                        (((cur_i == StQueued) && (tgt_i == StFree)) ||
                         ((cur_i == StFree) && (tgt_i == StQueued)));
      default:     go = 1'b0;
    endcase
  end

  always_comb begin
    move_o = '0;
    if (go) begin
      if ((cur_i == StFree) && (tgt_i == StDequeued)) begin
        move_o.ok             = free_i.has;
        move_o.free_op.remove = free_i.has;
      end else if ((cur_i == StFree) && (tgt_i == StQueued)) begin
        move_o.ok             = free_i.has && !data_i.full;
        move_o.free_op.remove = move_o.ok;
        move_o.data_op.push   = move_o.ok;
      end else if ((cur_i == StDequeued) && (tgt_i == StQueued)) begin
        move_o.ok           = !data_i.has && !data_i.full;
        move_o.data_op.push = move_o.ok;
      end else if ((cur_i == StDequeued) && (tgt_i == StFree)) begin
        move_o.ok           = !free_i.has && !free_i.full;
        move_o.free_op.push = move_o.ok;
      end else if ((cur_i == StQueued) && (tgt_i == StAcquired)) begin
        // stays in the data list
        move_o.ok = 1'b1;
      end else if (((cur_i == StQueued) || (cur_i == StAcquired)) && (tgt_i == StFree)) begin
        move_o.ok             = data_i.has && !free_i.full;
        move_o.data_op.remove = move_o.ok;
        move_o.free_op.push   = move_o.ok;
      end
    end
  end

endmodule

// ===== hw/rtl/buffer_queue_state_manager.sv =====
// Top level: request register, buffer state table, free and data lists, result register.
`timescale 1ns / 1ps

// Tracks up to 16 buffers through free, dequeued, queued and acquired, with an
// ordered free list and data list. A request is captured in an input register and
// fully resolved once the result register is empty or its result is being taken;
// then the state table, both lists and the result register update together, so
// one request is taken every cycle while out_ready_i does not hold a result back.
// The list heads and lengths come straight from the list registers, which hold
// the state left by the request whose result is on offer. After reset the block
// first builds the free list and takes no request while it does so.
// buffer_count takes effect only at that setup and at each reinit request.
module buffer_queue_state_manager import bqsm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [LenW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      kind_i,
  input  logic [KeyW-1:0] buffer_key_i,
  input  logic [StW-1:0]  target_state_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            ok_o,
  output logic [StW-1:0]  buffer_state_now_o,
  output logic            free_head_valid_o,
  output logic [KeyW-1:0] free_head_key_o,
  output logic            data_head_valid_o,
  output logic [KeyW-1:0] data_head_key_o,
  output logic [LenW-1:0] free_length_o,
  output logic [LenW-1:0] data_length_o
);

  logic [LenW-1:0] count_q;
  logic [LenW-1:0] live_q, live_d;
  logic            init_q;
  logic            in_valid_q, in_valid_d;
  logic [1:0]      kind_q;
  logic [KeyW-1:0] key_q;
  logic [StW-1:0]  tgt_q;
  logic            out_valid_q, out_valid_d;
  logic            ok_q, ok_d;
  logic [StW-1:0]  st_now_q, st_now_d;
  logic [StW-1:0]  states_q [NumBuffers];
  logic [StW-1:0]  states_d [NumBuffers];

  logic            advance;
  logic            accept;
  logic            is_reinit;
  logic            reinit;
  logic            apply;
  logic            in_range;
  logic [LenW-1:0] clamp_cnt;
  logic [StW-1:0]  cur;
  list_stat_t      free_stat, data_stat;
  list_op_t        free_op, data_op;
  move_t           move;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !init_q && (!in_valid_q || advance);
  assign accept     = in_valid_i && in_ready_o;
  assign in_valid_d = accept || (in_valid_q && !advance);

  assign is_reinit = (kind_q == KindReinit);
  assign reinit    = init_q || (advance && is_reinit);
  assign apply     = advance && !is_reinit;

  always_comb begin
    if (count_q == '0) begin
      clamp_cnt = LenW'(1);
    end else if (count_q > MaxCount) begin
      clamp_cnt = MaxCount;
    end else begin
      clamp_cnt = count_q;
    end
  end

  assign live_d   = reinit ? clamp_cnt : live_q;
  assign in_range = ({1'b0, key_q} < live_q);
  assign cur      = states_q[key_q];

  bqsm_rules u_rules (
    .kind_i     (kind_q),
    .in_range_i (in_range),
    .cur_i      (cur),
    .tgt_i      (tgt_q),
    .free_i     (free_stat),
    .data_i     (data_stat),
    .move_o     (move)
  );

  // drop list updates unless the request really resolves this cycle
  always_comb begin
    free_op.push   = apply && move.free_op.push;
    free_op.remove = apply && move.free_op.remove;
    data_op.push   = apply && move.data_op.push;
    data_op.remove = apply && move.data_op.remove;
  end

  bqsm_list u_free (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .reinit_i     (reinit),
    .reinit_len_i (clamp_cnt),
    .op_i         (free_op),
    .key_i        (key_q),
    .stat_o       (free_stat),
    .head_valid_o (free_head_valid_o),
    .head_key_o   (free_head_key_o),
    .len_o        (free_length_o)
  );

  bqsm_list u_data (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .reinit_i     (reinit),
    .reinit_len_i ('0),
    .op_i         (data_op),
    .key_i        (key_q),
    .stat_o       (data_stat),
    .head_valid_o (data_head_valid_o),
    .head_key_o   (data_head_key_o),
    .len_o        (data_length_o)
  );

  always_comb begin
    for (int i = 0; i < NumBuffers; i++) begin
      states_d[i] = states_q[i];
    end
    if (reinit) begin
      for (int i = 0; i < NumBuffers; i++) begin
        states_d[i] = StFree;
      end
    end else if (apply && move.ok) begin
      states_d[key_q] = tgt_q;
    end
  end

  // a reinit leaves every buffer free, so its reported state is free either way
  always_comb begin
    if (is_reinit) begin
      ok_d     = 1'b1;
      st_now_d = StFree;
    end else begin
      ok_d     = move.ok;
      st_now_d = in_range ? (move.ok ? tgt_q : cur) : StFree;
    end
  end

  assign out_valid_d = advance || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= ResetCount;
      live_q      <= ResetCount;
      init_q      <= 1'b1;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumBuffers; i++) begin
        states_q[i] <= StFree;
      end
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      live_q      <= live_d;
      init_q      <= 1'b0;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      for (int i = 0; i < NumBuffers; i++) begin
        states_q[i] <= states_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      key_q  <= buffer_key_i;
      tgt_q  <= target_state_i;
    end
    if (advance) begin
      ok_q     <= ok_d;
      st_now_q <= st_now_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign ok_o               = ok_q;
  assign buffer_state_now_o = st_now_q;

endmodule
